FILE: rtl/core/decimal_accumulator_machine_step_assert.svh
// assertion macros for the decimal accumulator machine
`ifndef DECIMAL_ACCUMULATOR_MACHINE_STEP_ASSERT_SVH
`define DECIMAL_ACCUMULATOR_MACHINE_STEP_ASSERT_SVH

// property that holds whenever reset is low
`define DAM_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// implication checked on the next cycle
`define DAM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/dam_pkg.sv
// shared types and constants for the decimal accumulator machine
package dam_pkg;

   localparam int WORD_W = 15;
   localparam int ADDR_W = 7;
   localparam int ST_W = 3;

   localparam logic signed [WORD_W-1:0] WORD_MAX = 15'sd9999;
   localparam logic signed [WORD_W-1:0] WORD_MIN = -15'sd9999;
   localparam logic [ADDR_W-1:0] STOP_PC = 7'd100;

   localparam logic [ST_W-1:0] ST_OK      = 3'd0;
   localparam logic [ST_W-1:0] ST_HALT    = 3'd1;
   localparam logic [ST_W-1:0] ST_OVF     = 3'd2;
   localparam logic [ST_W-1:0] ST_DIV0    = 3'd3;
   localparam logic [ST_W-1:0] ST_INVALID = 3'd4;

   localparam logic [6:0] OP_READ  = 7'd10;
   localparam logic [6:0] OP_WRITE = 7'd11;
   localparam logic [6:0] OP_LOAD  = 7'd20;
   localparam logic [6:0] OP_STORE = 7'd21;
   localparam logic [6:0] OP_ADD   = 7'd30;
   localparam logic [6:0] OP_SUB   = 7'd31;
   localparam logic [6:0] OP_DIV   = 7'd32;
   localparam logic [6:0] OP_MUL   = 7'd33;
   localparam logic [6:0] OP_BR    = 7'd40;
   localparam logic [6:0] OP_BRNEG = 7'd41;
   localparam logic [6:0] OP_BRZ   = 7'd42;
   localparam logic [6:0] OP_HALT  = 7'd43;

   // controller commands to the datapath
   typedef struct packed {
      logic capture;    // latch request fields, start a memory read
      logic load;       // write load word and restart
      logic split;      // split fetched word into opcode and operand
      logic opd_read;   // read operand word
      logic exec;       // run an instruction other than divide or multiply
      logic div_start;
      logic div_step;
      logic div_end;
      logic mul_end;
      logic halted_step;
   } dam_cmd_type;

   typedef struct packed {
      logic is_load;
      logic halted;     // halt flag or counter off the end
      logic is_div;
      logic is_mul;
      logic div_last;
   } dam_sts_type;

endpackage

FILE: rtl/core/dam_ctrl.sv
// controller state machine for the decimal accumulator machine
module dam_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output dam_pkg::dam_cmd_type  cmd,
   input  dam_pkg::dam_sts_type  sts
);
   import dam_pkg::*;

   typedef enum logic [8:0] {
      S_IDLE  = 9'b000000001,
      S_DEC   = 9'b000000010,
      S_SPLIT = 9'b000000100,
      S_OPD   = 9'b000001000,
      S_EXEC  = 9'b000010000,
      S_DIV   = 9'b000100000,
      S_DEND  = 9'b001000000,
      S_MEND  = 9'b010000000,
      S_OUT   = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   logic      out_ff, out_in;

   assign req_stall = (state_ff != S_IDLE) || (out_ff && rsp_stall);
   assign rsp_valid = out_ff;

   always_comb begin
      state_in = state_ff;
      out_in = out_ff && rsp_stall;
      cmd = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && !req_stall) begin
               cmd.capture = 1'b1;
               state_in = S_DEC;
            end
         end
         S_DEC: begin
            if (sts.is_load) begin
               cmd.load = 1'b1;
               state_in = S_OUT;
            end else if (sts.halted) begin
               cmd.halted_step = 1'b1;
               state_in = S_OUT;
            end else begin
               state_in = S_SPLIT;
            end
         end
         S_SPLIT: begin
            cmd.split = 1'b1;
            state_in = S_OPD;
         end
         S_OPD: begin
            cmd.opd_read = 1'b1;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            if (sts.is_div) begin
               cmd.div_start = 1'b1;
               state_in = S_DIV;
            end else if (sts.is_mul) begin
               state_in = S_MEND;
            end else begin
               cmd.exec = 1'b1;
               state_in = S_OUT;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) state_in = S_DEND;
         end
         S_DEND: begin
            cmd.div_end = 1'b1;
            state_in = S_OUT;
         end
         S_MEND: begin
            cmd.mul_end = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!(out_ff && rsp_stall)) begin
               out_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         out_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         out_ff <= out_in;
      end
   end

   `include "decimal_accumulator_machine_step_assert.svh"

   `DAM_ASSERT(a_onehot, clock, reset, $onehot(state_ff), "state not one-hot")
   `DAM_ASSERT(a_busy_stall, clock, reset, state_ff == S_IDLE || req_stall, "input open while busy")
   `DAM_ASSERT_NEXT(a_out_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid, "result dropped")
endmodule

FILE: rtl/core/dam_dp.sv
// datapath: memory, registers, multiplier and serial divider
module dam_dp #(
   parameter int MEM_WORDS = 100
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_cmd,
   input  logic [dam_pkg::ADDR_W-1:0]       req_load_addr,
   input  logic signed [dam_pkg::WORD_W-1:0] req_word_in,
   input  dam_pkg::dam_cmd_type             cmd,
   output dam_pkg::dam_sts_type             sts,
   output logic [dam_pkg::ST_W-1:0]         rsp_status,
   output logic                             rsp_print_valid,
   output logic signed [dam_pkg::WORD_W-1:0] rsp_print_value,
   output logic [dam_pkg::ADDR_W-1:0]       rsp_next_pc,
   output logic signed [dam_pkg::WORD_W-1:0] rsp_acc_value,
   output logic                             rsp_is_halted
);
   import dam_pkg::*;

   localparam int MA_W = $clog2(MEM_WORDS);
   localparam logic [ADDR_W-1:0] MEM_TOP = ADDR_W'(MEM_WORDS);
   localparam int CNT_W = 4;
   localparam logic [CNT_W-1:0] DIV_LAST = 4'd13;

   logic signed [WORD_W-1:0] mem [MEM_WORDS];
   logic [MEM_WORDS-1:0] vld_ff;
   logic signed [WORD_W-1:0] rd_ff;
   logic rd_vld_ff;

   logic cmd_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic signed [WORD_W-1:0] win_ff;
   logic signed [WORD_W-1:0] acc_ff;
   logic [ADDR_W-1:0] pc_ff;
   logic halt_ff;
   logic [6:0] op_ff;
   logic op_neg_ff;
   logic [ADDR_W-1:0] opd_ff;
   logic signed [29:0] prod_ff;
   logic [13:0] quo_ff, rem_ff, dvs_ff;
   logic neg_ff;
   logic [CNT_W-1:0] cnt_ff;

   logic [ST_W-1:0] st_ff;
   logic pv_ff;
   logic signed [WORD_W-1:0] pval_ff;

   // memory read address and write
   logic [ADDR_W-1:0] rd_addr;
   logic wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic signed [WORD_W-1:0] wr_data;
   logic signed [WORD_W-1:0] rd_word;
   assign rd_word = rd_vld_ff ? rd_ff : '0;

   function automatic logic signed [WORD_W-1:0] sat(input logic signed [WORD_W-1:0] x);
      if (x > WORD_MAX) return WORD_MAX;
      if (x < WORD_MIN) return WORD_MIN;
      return x;
   endfunction

   // word / 100 and word % 100 for non-negative words; negatives are invalid
   function automatic logic [6:0] op_of(input logic signed [WORD_W-1:0] w);
      logic [27:0] p;
      logic [13:0] u;
      u = w[13:0];
      p = 28'(u) * 28'd5243;
      return 7'(p >> 19);
   endfunction

   function automatic logic [ADDR_W-1:0] opd_of(input logic signed [WORD_W-1:0] w);
      logic signed [WORD_W-1:0] a;
      logic signed [WORD_W-1:0] q;
      logic signed [WORD_W-1:0] r;
      logic [27:0] p;
      a = w[WORD_W-1] ? -w : w;
      p = 28'(a[13:0]) * 28'd5243;
      q = WORD_W'(p >> 19);
      r = a - WORD_W'(q * 15'sd100);
      // operand of a negative word is negative and maps to STOP_PC, or to 0 if it is zero
      return w[WORD_W-1] ? (r == 0 ? '0 : STOP_PC) : ADDR_W'(r);
   endfunction

   // operand word stays on the read port through the execute cycle
   always_comb begin
      if (cmd.split) rd_addr = opd_of(rd_word);
      else if (cmd.opd_read) rd_addr = opd_ff;
      else rd_addr = pc_ff;
   end

   logic signed [WORD_W-1:0] m;
   assign m = (opd_ff < MEM_TOP) ? rd_word : '0;

   logic signed [15:0] sum;
   logic signed [WORD_W-1:0] win_sat;
   assign win_sat = sat(win_ff);
   assign sum = (op_ff == OP_ADD) ? (16'(acc_ff) + 16'(m)) : (16'(acc_ff) - 16'(m));

   assign sts.is_load = !cmd_ff;
   assign sts.halted = halt_ff || (pc_ff >= MEM_TOP);
   assign sts.is_div = (op_ff == OP_DIV) && !op_neg_ff;
   assign sts.is_mul = (op_ff == OP_MUL) && !op_neg_ff;
   assign sts.div_last = (cnt_ff == DIV_LAST);

   logic [14:0] trial;
   assign trial = {rem_ff, quo_ff[13]} - {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr[MA_W-1:0]] <= wr_data;
      rd_ff <= mem[rd_addr[MA_W-1:0]];
      rd_vld_ff <= (rd_addr < MEM_TOP) && vld_ff[rd_addr[MA_W-1:0]];
   end

   always_comb begin
      wr_en = 1'b0;
      wr_addr = addr_ff;
      wr_data = win_sat;
      if (cmd.load && addr_ff < MEM_TOP) wr_en = 1'b1;
      if (cmd.exec && !op_neg_ff && opd_ff < MEM_TOP) begin
         if (op_ff == OP_READ) begin
            wr_en = 1'b1;
            wr_addr = opd_ff;
         end else if (op_ff == OP_STORE) begin
            wr_en = 1'b1;
            wr_addr = opd_ff;
            wr_data = acc_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         acc_ff <= '0;
         pc_ff <= '0;
         halt_ff <= 1'b0;
      end else begin
         if (wr_en) vld_ff[wr_addr[MA_W-1:0]] <= 1'b1;
         if (cmd.load) begin
            acc_ff <= '0;
            pc_ff <= '0;
            halt_ff <= 1'b0;
         end
         if (cmd.halted_step) begin
            halt_ff <= 1'b1;
            pc_ff <= STOP_PC;
         end
         if (cmd.split) pc_ff <= pc_ff + 7'd1;
         if (cmd.exec) begin
            logic [ADDR_W-1:0] npc;
            logic hl;
            npc = pc_ff;
            hl = 1'b0;
            if (!op_neg_ff) begin
               case (op_ff)
                  OP_LOAD: acc_ff <= m;
                  OP_ADD, OP_SUB: begin
                     if (sum > 16'sd9999 || sum < -16'sd9999) hl = 1'b1;
                     else acc_ff <= WORD_W'(sum);
                  end
                  OP_BR: npc = opd_ff;
                  OP_BRNEG: if (acc_ff < 0) npc = opd_ff;
                  OP_BRZ: if (acc_ff == 0) npc = opd_ff;
                  OP_HALT: hl = 1'b1;
                  default: ;
               endcase
            end
            if (hl || npc >= MEM_TOP) begin
               halt_ff <= 1'b1;
               pc_ff <= STOP_PC;
            end else begin
               pc_ff <= npc;
            end
         end
         if (cmd.div_start && m == 0) begin
            halt_ff <= 1'b1;
            pc_ff <= STOP_PC;
         end
         if (cmd.div_end) begin
            if (dvs_ff != 0) acc_ff <= neg_ff ? -WORD_W'(quo_ff) : WORD_W'(quo_ff);
            if (dvs_ff == 0 || pc_ff >= MEM_TOP) begin
               halt_ff <= 1'b1;
               pc_ff <= STOP_PC;
            end
         end
         if (cmd.mul_end) begin
            if (prod_ff > 30'sd9999 || prod_ff < -30'sd9999) begin
               halt_ff <= 1'b1;
               pc_ff <= STOP_PC;
            end else begin
               acc_ff <= WORD_W'(prod_ff);
               if (pc_ff >= MEM_TOP) begin
                  halt_ff <= 1'b1;
                  pc_ff <= STOP_PC;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cmd_ff <= req_cmd;
         addr_ff <= req_load_addr;
         win_ff <= req_word_in;
      end
      if (cmd.split) begin
         op_ff <= op_of(rd_word);
         op_neg_ff <= rd_word[WORD_W-1];
         opd_ff <= opd_of(rd_word);
      end
      if (cmd.opd_read) prod_ff <= 30'(acc_ff) * 30'(m);
      if (cmd.div_start) begin
         quo_ff <= acc_ff[WORD_W-1] ? 14'(-acc_ff) : acc_ff[13:0];
         dvs_ff <= m[WORD_W-1] ? 14'(-m) : m[13:0];
         neg_ff <= acc_ff[WORD_W-1] ^ m[WORD_W-1];
         rem_ff <= '0;
         cnt_ff <= '0;
      end
      if (cmd.div_step) begin
         cnt_ff <= cnt_ff + 4'd1;
         if (!trial[14]) begin
            rem_ff <= trial[13:0];
            quo_ff <= {quo_ff[12:0], 1'b1};
         end else begin
            rem_ff <= {rem_ff[12:0], quo_ff[13]};
            quo_ff <= {quo_ff[12:0], 1'b0};
         end
      end
      // result word bookkeeping
      if (cmd.capture) begin
         st_ff <= ST_OK;
         pv_ff <= 1'b0;
         pval_ff <= '0;
      end
      if (cmd.halted_step) st_ff <= ST_HALT;
      if (cmd.exec) begin
         if (op_neg_ff) st_ff <= ST_INVALID;
         else begin
            case (op_ff)
               OP_WRITE: begin
                  pv_ff <= 1'b1;
                  pval_ff <= m;
               end
               OP_ADD, OP_SUB:
                  if (sum > 16'sd9999 || sum < -16'sd9999) st_ff <= ST_OVF;
               OP_HALT: st_ff <= ST_HALT;
               OP_READ, OP_LOAD, OP_STORE, OP_BR, OP_BRNEG, OP_BRZ: ;
               default: st_ff <= ST_INVALID;
            endcase
         end
      end
      if (cmd.div_end && dvs_ff == 0) st_ff <= ST_DIV0;
      if (cmd.mul_end && (prod_ff > 30'sd9999 || prod_ff < -30'sd9999)) st_ff <= ST_OVF;
   end

   assign rsp_status = st_ff;
   assign rsp_print_valid = pv_ff;
   assign rsp_print_value = pval_ff;
   assign rsp_next_pc = pc_ff;
   assign rsp_acc_value = acc_ff;
   assign rsp_is_halted = halt_ff;

   `include "decimal_accumulator_machine_step_assert.svh"

   `DAM_ASSERT(a_pc_range, clock, reset, pc_ff <= STOP_PC, "counter beyond stop")
   `DAM_ASSERT(a_halt_pc, clock, reset, !halt_ff || pc_ff == STOP_PC, "halted, counter running")
   `DAM_ASSERT(a_acc_range, clock, reset, acc_ff <= WORD_MAX && acc_ff >= WORD_MIN, "acc range")
endmodule

FILE: rtl/core/decimal_accumulator_machine_step.sv
// top level of the decimal accumulator machine
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/stall    | cmd, load_addr, word_in
//   rsp     | out       | rsp_valid/stall    | status, print, next_pc, acc, halted
// load words and halted steps go from decode to output; instructions split, read the
// operand and execute; divide then runs a 14-step restoring divider
// reset is synchronous and clears counter, accumulator, halt flag and memory valid bits
// the result register holds under rsp_stall; a new word is taken once it drains
module decimal_accumulator_machine_step #(
   parameter int MEM_WORDS = 100
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_cmd,
   input  logic [dam_pkg::ADDR_W-1:0]        req_load_addr,
   input  logic signed [dam_pkg::WORD_W-1:0] req_word_in,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [dam_pkg::ST_W-1:0]          rsp_status,
   output logic                              rsp_print_valid,
   output logic signed [dam_pkg::WORD_W-1:0] rsp_print_value,
   output logic [dam_pkg::ADDR_W-1:0]        rsp_next_pc,
   output logic signed [dam_pkg::WORD_W-1:0] rsp_acc_value,
   output logic                              rsp_is_halted
);
   import dam_pkg::*;

   dam_cmd_type cmd;
   dam_sts_type sts;

   dam_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .cmd(cmd), .sts(sts)
   );

   dam_dp #(.MEM_WORDS(MEM_WORDS)) u_dp (
      .clock(clock), .reset(reset),
      .req_cmd(req_cmd), .req_load_addr(req_load_addr), .req_word_in(req_word_in),
      .cmd(cmd), .sts(sts),
      .rsp_status(rsp_status), .rsp_print_valid(rsp_print_valid),
      .rsp_print_value(rsp_print_value), .rsp_next_pc(rsp_next_pc),
      .rsp_acc_value(rsp_acc_value), .rsp_is_halted(rsp_is_halted)
   );
endmodule
